// ----- rtl/bcc_pkg.sv -----
package bcc_pkg;

  // Field widths
  localparam int unsigned TimeW = 32;
  localparam int unsigned ThrW  = 16;

  // Reset values of the thresholds
  localparam logic [ThrW-1:0] DebounceRst = 16'd5;
  localparam logic [ThrW-1:0] WindowRst   = 16'd1500;
  localparam logic [ThrW-1:0] LongRst     = 16'd5000;

  // Register indexes (word address bits [3:2])
  localparam logic [1:0] RegDebounce = 2'd0;
  localparam logic [1:0] RegWindow   = 2'd1;
  localparam logic [1:0] RegLong     = 2'd2;

  // Status codes reported for each sample
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  // Classifier phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_FIRST  = 5'b00010,
    PH_WAIT   = 5'b00100,
    PH_SECOND = 5'b01000,
    PH_LONG   = 5'b10000
  } phase_t;

  // Threshold set handed from the register file to the classifier
  typedef struct packed {
    logic [ThrW-1:0] debounce_ms;
    logic [ThrW-1:0] click_window_ms;
    logic [ThrW-1:0] long_press_ms;
  } cfg_t;

endpackage

// ----- rtl/bcc_cfg.sv -----
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Threshold registers, upper data bits dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DebounceRst;
      cfg.click_window_ms <= WindowRst;
      cfg.long_press_ms   <= LongRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDebounce: cfg.debounce_ms     <= pwdata[ThrW-1:0];
        RegWindow:   cfg.click_window_ms <= pwdata[ThrW-1:0];
        RegLong:     cfg.long_press_ms   <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegDebounce: prdata = {16'd0, cfg.debounce_ms};
      RegWindow:   prdata = {16'd0, cfg.click_window_ms};
      RegLong:     prdata = {16'd0, cfg.long_press_ms};
      default:     prdata = '0;
    endcase
  end

endmodule

// ----- rtl/bcc_fsm.sv -----
module bcc_fsm
  import bcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [TimeW-1:0] now_ms,
  input  logic             pin_level,
  input  cfg_t             cfg,
  output status_t          press_event
);

  phase_t           phase, phase_next;
  logic [TimeW-1:0] press_time, press_time_next;
  logic [TimeW-1:0] release_time, release_time_next;

  logic             pressed;
  logic [TimeW-1:0] since_press;
  logic [TimeW-1:0] since_release;
  logic [TimeW-1:0] deb_w;
  logic [TimeW-1:0] win_w;
  logic [TimeW-1:0] long_w;

  // Wrapping elapsed times and widened thresholds
  assign pressed       = ~pin_level;
  assign since_press   = now_ms - press_time;
  assign since_release = now_ms - release_time;
  assign deb_w         = {{(TimeW-ThrW){1'b0}}, cfg.debounce_ms};
  assign win_w         = {{(TimeW-ThrW){1'b0}}, cfg.click_window_ms};
  assign long_w        = {{(TimeW-ThrW){1'b0}}, cfg.long_press_ms};

  // Next state and status for the current sample
  always_comb begin
    phase_next        = phase;
    press_time_next   = press_time;
    release_time_next = release_time;
    press_event       = ST_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next      = PH_FIRST;
          press_time_next = now_ms;
        end
      end
      PH_FIRST: begin
        priority if (!pressed && since_press < deb_w) begin
          phase_next = PH_IDLE;
        end else if (!pressed) begin
          phase_next        = PH_WAIT;
          release_time_next = now_ms;
        end else if (since_press > long_w) begin
          phase_next        = PH_LONG;
          release_time_next = now_ms;
        end else begin
          phase_next = phase;
        end
      end
      PH_WAIT: begin
        priority if (since_press > win_w) begin
          press_event = ST_SINGLE;
          phase_next  = PH_IDLE;
        end else if (pressed && since_release > deb_w) begin
          phase_next      = PH_SECOND;
          press_time_next = now_ms;
        end else begin
          phase_next = phase;
        end
      end
      PH_SECOND: begin
        if (!pressed && since_press > deb_w) begin
          press_event       = ST_DOUBLE;
          phase_next        = PH_IDLE;
          release_time_next = now_ms;
        end
      end
      PH_LONG: begin
        if (!pressed) begin
          press_event       = ST_LONG;
          phase_next        = PH_IDLE;
          release_time_next = now_ms;
        end
      end
      default: ;
    endcase
  end

  // State update, one sample per advance
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      press_time   <= '0;
      release_time <= '0;
    end else if (adv) begin
      phase        <= phase_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
    end
  end

`ifndef SYNTH
  a_event_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && press_event != ST_NONE) |=> phase == PH_IDLE)
    else $error("reported event did not return to idle");

  a_press_start: assert property (@(posedge clk) disable iff (rst)
    (adv && phase == PH_IDLE && !pin_level)
      |=> (phase == PH_FIRST && press_time == $past(now_ms)))
    else $error("press from idle not recorded");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(phase) && $stable(press_time) && $stable(release_time)))
    else $error("state moved without a sample");
`endif

endmodule

// ----- rtl/button_click_classifier_unit.sv -----
// Button click classifier.
// Input stream: one word per sample, s_tdata carries the millisecond
// timestamp and the raw active-low pin level. Output stream: one word per
// sample, m_tdata carries the status (none, single, double, long press).
// Thresholds (debounce, click window, long press) are set over the APB
// port at byte addresses 0, 4 and 8; write them only while idle.
// An accepted word passes through the input register, then the result
// register, before it shows on m_tvalid. Throughput: one word per cycle
// while the receiver does not stall; the classifier updates its state in
// the cycle the sample moves from the input into the result register.
// When the receiver stalls, the result register holds its word and the
// input register keeps accepting until it is full as well; s_tready then
// drops until the output drains.
// Reset clears both pipeline valids, returns the classifier to idle with
// zero timestamps and loads the thresholds with 5, 1500 and 5000 ms.
module button_click_classifier_unit
  import bcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] now_ms, [32] pin_level, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] press_event, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t             cfg;
  logic             in_valid;
  logic [TimeW-1:0] in_now;
  logic             in_pin;
  logic             out_free;
  logic             adv;
  status_t          status_c;
  status_t          status_q;

  bcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: stage moves when the next one has room
  assign out_free = ~m_tvalid | m_tready;
  assign adv      = in_valid & out_free;
  assign s_tready = ~in_valid | out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_now <= s_tdata[TimeW-1:0];
      in_pin <= s_tdata[TimeW];
    end
  end

  bcc_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .now_ms      (in_now),
    .pin_level   (in_pin),
    .cfg         (cfg),
    .press_event (status_c)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_q <= status_c;
    end
  end

  assign m_tdata = {6'd0, status_q};

endmodule
